>>> src/sliding_window_median_macros.svh
// ---------------------------------------------------------------------------
// Sliding window median: assertion macros
// Clocked property wrappers for the RTL that carries checks.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/swm_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window median: package
// Sizes, register map, cell control struct and window size helper.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW         = $clog2(WINDOW_MAX + 1);
  localparam int WSIZE_W    = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);
  localparam logic               REG_WSIZE   = 1'b0;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

  // zero counts as one, anything above the ring depth is clamped
  function automatic logic [KW-1:0] eff_k(input logic [WSIZE_W-1:0] w);
    logic [KW-1:0] kk;
    if (w == '0) begin
      kk = KW'(1);
    end else if (32'(w) > WINDOW_MAX) begin
      kk = KW'(WINDOW_MAX);
    end else begin
      kk = KW'(w);
    end
    return kk;
  endfunction

endpackage

>>> src/swm_sample_if.sv
// ---------------------------------------------------------------------------
// Sliding window median: sample channel
// Valid/ready channel carrying one input sample per beat.
// ---------------------------------------------------------------------------
interface swm_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [swm_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> src/swm_median_if.sv
// ---------------------------------------------------------------------------
// Sliding window median: result channel
// Valid/ready channel carrying one median per beat.
// ---------------------------------------------------------------------------
interface swm_median_if;
  logic                              valid;
  logic                              ready;
  logic signed [swm_pkg::DATA_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

>>> src/swm_cfg.sv
// ---------------------------------------------------------------------------
// Sliding window median: register block
// APB-style port holding the window size register.
// ---------------------------------------------------------------------------
module swm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [swm_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [swm_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready,
  output logic [swm_pkg::WSIZE_W-1:0]         window_size
);

  logic [swm_pkg::WSIZE_W-1:0] wsize_r;
  logic [swm_pkg::WSIZE_W-1:0] wsize_nxt;
  logic                        wr_en;

  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    wsize_nxt = wsize_r;
    if (wr_en && (cfg_paddr[2] == swm_pkg::REG_WSIZE)) begin
      wsize_nxt = cfg_pwdata[swm_pkg::WSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= swm_pkg::WSIZE_RESET;
    end else begin
      wsize_r <= wsize_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == swm_pkg::REG_WSIZE) begin
      cfg_prdata = swm_pkg::PDATA_W'(wsize_r);
    end
  end

  assign cfg_pready  = 1'b1;
  assign window_size = wsize_r;

endmodule

>>> src/swm_cell.sv
// ---------------------------------------------------------------------------
// Sliding window median: rank cell
// Holds one window sample, a circulating probe and the sample's rank count.
// ---------------------------------------------------------------------------
module swm_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swm_pkg::cell_ctl_t                  ctl,
  input  logic [swm_pkg::IDX_W-1:0]           idx,
  input  logic signed [swm_pkg::DATA_W-1:0]   value_in,
  input  logic signed [swm_pkg::DATA_W-1:0]   probe_in,
  input  logic [swm_pkg::IDX_W-1:0]           org_in,
  output logic signed [swm_pkg::DATA_W-1:0]   value,
  output logic signed [swm_pkg::DATA_W-1:0]   probe,
  output logic [swm_pkg::IDX_W-1:0]           org,
  output logic [swm_pkg::IDX_W-1:0]           rank
);

  logic signed [swm_pkg::DATA_W-1:0] value_r;
  logic signed [swm_pkg::DATA_W-1:0] probe_r;
  logic [swm_pkg::IDX_W-1:0]         org_r;
  logic [swm_pkg::IDX_W-1:0]         rank_r;
  logic                              lt;

  // probe sorts below this sample; equal values break on position
  assign lt = (probe_r < value_r) || ((probe_r == value_r) && (org_r < idx));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= value_in;
      probe_r <= value_in;
      org_r   <= idx;
    end else if (ctl.step) begin
      probe_r <= probe_in;
      org_r   <= org_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else if (ctl.load) begin
      rank_r <= '0;
    end else if (ctl.step) begin
      rank_r <= rank_r + swm_pkg::IDX_W'(lt);
    end
  end

  assign value = value_r;
  assign probe = probe_r;
  assign org   = org_r;
  assign rank  = rank_r;

endmodule

>>> src/sliding_window_median.sv
// ---------------------------------------------------------------------------
// Sliding window median: top level
// Running lower median over the last k samples, built as a row of rank cells.
//
//   channel  | dir | payload            | beat
//   in_s     | in  | sample  (32, s)    | valid & ready
//   out_s    | out | median  (32, s)    | valid & ready
//   cfg_*    | in  | window_size (7, u) | psel & penable & pwrite & pready
//
// A sample that gives no median only loads the row, which stays idle. One
// that gives a median passes the accept, k compare steps while the probe ring
// turns once through the k window cells, and a final step to pick the cell
// of median rank. Synchronous active-low reset; no clearing pass. The output
// register lets the next sample be taken while a median waits; a stalled
// output holds the row in its final step until the register frees.
// ---------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module sliding_window_median (
  input  logic                                clk,
  input  logic                                rst_n,
  swm_sample_if.sink                          in_s,
  swm_median_if.source                        out_s,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [swm_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [swm_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int N = swm_pkg::WINDOW_MAX;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [swm_pkg::KW-1:0]             fill_r, fill_nxt, fill_inc;
  logic [swm_pkg::IDX_W-1:0]          cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [swm_pkg::DATA_W-1:0]  median_r, median_nxt;

  logic [swm_pkg::WSIZE_W-1:0]        window_size;
  logic [swm_pkg::KW-1:0]             k;
  logic [swm_pkg::KW-1:0]             k_m1;
  logic [swm_pkg::IDX_W-1:0]          mid;
  logic                               accept;
  logic                               out_free;
  swm_pkg::cell_ctl_t                 ctl;

  logic signed [swm_pkg::DATA_W-1:0]  value   [N];
  logic signed [swm_pkg::DATA_W-1:0]  probe   [N];
  logic [swm_pkg::IDX_W-1:0]          org     [N];
  logic [swm_pkg::IDX_W-1:0]          rank    [N];
  logic signed [swm_pkg::DATA_W-1:0]  v_in    [N];
  logic signed [swm_pkg::DATA_W-1:0]  p_in    [N];
  logic [swm_pkg::IDX_W-1:0]          o_in    [N];
  logic [N-1:0]                       match;
  logic signed [swm_pkg::DATA_W-1:0]  pick;

  swm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .window_size (window_size)
  );

  assign k    = swm_pkg::eff_k(window_size);
  assign k_m1 = k - swm_pkg::KW'(1);
  assign mid  = swm_pkg::IDX_W'(k_m1 >> 1);

  assign in_s.ready = (state_r == S_IDLE);
  assign accept     = in_s.valid & in_s.ready;
  assign out_free   = !out_valid_r || out_s.ready;

  assign ctl.load = accept;
  assign ctl.step = (state_r == S_RUN);

  // probe ring closes over the first k cells
  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign v_in[gi] = in_s.sample;
        assign p_in[gi] = probe[k_m1[swm_pkg::IDX_W-1:0]];
        assign o_in[gi] = org[k_m1[swm_pkg::IDX_W-1:0]];
      end else begin : g_body
        assign v_in[gi] = value[gi-1];
        assign p_in[gi] = probe[gi-1];
        assign o_in[gi] = org[gi-1];
      end

      assign match[gi] = (rank[gi] == mid) && (swm_pkg::KW'(gi) < k);

      swm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (swm_pkg::IDX_W'(gi)),
        .value_in (v_in[gi]),
        .probe_in (p_in[gi]),
        .org_in   (o_in[gi]),
        .value    (value[gi]),
        .probe    (probe[gi]),
        .org      (org[gi]),
        .rank     (rank[gi])
      );
    end
  endgenerate

  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        pick = pick | value[i];
      end
    end
  end

  assign fill_inc = (fill_r == swm_pkg::KW'(N)) ? fill_r : fill_r + swm_pkg::KW'(1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    median_nxt    = median_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fill_nxt = fill_inc;
          cnt_nxt  = '0;
          if (fill_inc >= k) begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + swm_pkg::IDX_W'(1);
        if (swm_pkg::KW'(cnt_r) == k_m1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          median_nxt    = pick;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_s.valid  = out_valid_r;
  assign out_s.median = median_r;

  `SWM_ASSERT_IMP(a_one_median_cell, clk, rst_n, state_r == S_DONE, $onehot(match), "median rank not unique")
  `SWM_ASSERT_IMP(a_cnt_in_window, clk, rst_n, state_r == S_RUN, swm_pkg::KW'(cnt_r) < k, "compare count past window")
  `SWM_ASSERT_NXT(a_out_from_done, clk, rst_n, !out_valid_r && state_r != S_DONE, !out_valid_r, "median without rank pass")
  `SWM_ASSERT_IMP(a_run_needs_fill, clk, rst_n, state_r == S_RUN, fill_r >= k, "rank pass on short window")

endmodule

>>> verif/sliding_window_median_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sliding window median: testbench
// Streams signed samples into the filter and checks every median against a
// behavioural window copy or a typed value. A short table covers the reset
// window, the extremes, window sizes zero, one, two, the ring depth and
// beyond, the unused register slot and a size change mid-stream. Random
// phases follow, each with its own window size, data style and idling.
// ---------------------------------------------------------------------------
module sliding_window_median_test;

  localparam int WINDOW_MAX = swm_pkg::WINDOW_MAX;
  localparam int DATA_W     = swm_pkg::DATA_W;
  localparam int IDX_W      = swm_pkg::IDX_W;
  localparam int WSIZE_W    = swm_pkg::WSIZE_W;
  localparam int PADDR_W    = swm_pkg::PADDR_W;
  localparam int PDATA_W    = swm_pkg::PDATA_W;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = WINDOW_MAX + 8;

  localparam logic [PADDR_W-1:0] WSIZE_ADDR = PADDR_W'(swm_pkg::REG_WSIZE) << 2;
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

  localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] S_MAX = 32'h7fff_ffff;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_VALUE} exp_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [PADDR_W-1:0]  addr;
    logic [DATA_W-1:0]   data;
    exp_kind_t           how;
    logic [DATA_W-1:0]   med;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_SAMPLE, '0, 32'd5,          EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, -32'sd7,        EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'd100,        EXP_VALUE, 32'd5},
    '{ROW_SAMPLE, '0, S_MIN,          EXP_VALUE, -32'sd7},
    '{ROW_SAMPLE, '0, S_MAX,          EXP_VALUE, 32'd100},
    '{ROW_WRITE,  WSIZE_ADDR, 32'd0,  EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'd0,          EXP_VALUE, 32'd0},
    '{ROW_SAMPLE, '0, -32'sd1,        EXP_VALUE, -32'sd1},
    '{ROW_SAMPLE, '0, S_MAX,          EXP_VALUE, S_MAX},
    '{ROW_SAMPLE, '0, S_MIN,          EXP_VALUE, S_MIN},
    '{ROW_WRITE,  WSIZE_ADDR, 32'd1,  EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'd42,         EXP_VALUE, 32'd42},
    '{ROW_WRITE,  WSIZE_ADDR, 32'd2,  EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'haaaa_aaaa,  EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, 32'h5555_5555,  EXP_MODEL, '0},
    '{ROW_WRITE,  WSIZE_ADDR, 32'd64, EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'd1,          EXP_NONE,  '0},
    '{ROW_WRITE,  SPARE_ADDR, 32'd9,  EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, 32'd2,          EXP_NONE,  '0},
    '{ROW_WRITE,  WSIZE_ADDR, 32'hffff_ff7f, EXP_NONE, '0},
    '{ROW_SAMPLE, '0, 32'd3,          EXP_NONE,  '0},
    '{ROW_WRITE,  WSIZE_ADDR, 32'd5,  EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, -32'sd100,      EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, 32'hffff_ffff,  EXP_MODEL, '0}
  };

  logic clk;
  logic rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  swm_sample_if sample_ch ();
  swm_median_if median_ch ();

  sliding_window_median DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (sample_ch),
    .out_s       (median_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // window copy
  logic signed [DATA_W-1:0] window_ring [WINDOW_MAX];
  logic [IDX_W-1:0]         ring_wr_ptr;
  int                       ring_fill;
  logic [WSIZE_W-1:0]       window_size_q;

  logic signed [DATA_W-1:0] expected_medians [$];
  bit  failed;
  int  cycle_count;
  int  send_gap_pct;
  int  stall_pct;
  int  stall_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // push one sample into the window, return the lower median if one is due
  function automatic bit median_step(input logic signed [DATA_W-1:0] s,
                                     output logic signed [DATA_W-1:0] m);
    logic signed [DATA_W-1:0] sorted_win [WINDOW_MAX];
    logic signed [DATA_W-1:0] key;
    logic [IDX_W-1:0]         idx;
    int k;
    int j;
    if (window_size_q == '0) begin
      k = 1;
    end else if (int'(window_size_q) > WINDOW_MAX) begin
      k = WINDOW_MAX;
    end else begin
      k = int'(window_size_q);
    end
    window_ring[ring_wr_ptr] = s;
    ring_wr_ptr = ring_wr_ptr + 1'b1;
    if (ring_fill < WINDOW_MAX) begin
      ring_fill++;
    end
    m = '0;
    if (ring_fill < k) begin
      return 1'b0;
    end
    for (int i = 0; i < k; i++) begin
      idx = ring_wr_ptr - IDX_W'(i + 1);
      key = window_ring[idx];
      j = i;
      while (j > 0 && sorted_win[j-1] > key) begin
        sorted_win[j] = sorted_win[j-1];
        j--;
      end
      sorted_win[j] = key;
    end
    m = sorted_win[(k - 1) / 2];
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == WSIZE_ADDR) begin
      window_size_q = data[WSIZE_W-1:0];
    end
  endtask

  // hold off the sender until every median is back and the row is idle
  task automatic quiesce();
    sample_ch.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] value, input exp_kind_t how,
                             input logic [DATA_W-1:0] typed_med);
    logic signed [DATA_W-1:0] m;
    bit got;
    int gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    @(posedge clk);
    while (!(sample_ch.valid && sample_ch.ready)) @(posedge clk);
    got = median_step(value, m);
    case (how)
      EXP_MODEL: begin
        if (got) expected_medians.push_back(m);
      end
      EXP_VALUE: begin
        expected_medians.push_back(typed_med);
      end
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_sample(input int style);
    if ($urandom_range(0, 9) == 0) begin
      return $urandom;
    end
    case (style)
      1: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
      2: begin
        case ($urandom_range(0, 5))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          3: return '1;
          4: return S_MIN + DATA_W'($urandom_range(0, 3));
          default: return S_MAX - DATA_W'($urandom_range(0, 3));
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, every beat checked against the oldest median
  always @(posedge clk) begin : median_sink
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      median_ch.ready <= 1'b0;
    end else begin
      if (median_ch.valid && median_ch.ready) begin
        if (expected_medians.size() == 0) begin
          $error("median: expected none, actual %0d", median_ch.median);
          failed = 1'b1;
        end else begin
          want = expected_medians.pop_front();
          if (median_ch.median !== want) begin
            $error("median: expected %0d, actual %0d", want, median_ch.median);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        median_ch.ready <= 1'b0;
      end else begin
        median_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int random_sent;
    int phase;
    int len;
    int style;
    int pause_at;
    int k_eff;
    logic [WSIZE_W-1:0] wsize;
    dir_row_t row;
    rst_n           = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    send_gap_pct    = 20;
    stall_pct       = 20;
    ring_wr_ptr     = '0;
    ring_fill       = 0;
    window_size_q   = swm_pkg::WSIZE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        quiesce();
        write_reg(row.addr, row.data);
      end else begin
        send_sample(row.data, row.how, row.med);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: wsize = '0;
        1: wsize = WSIZE_W'($urandom_range(WINDOW_MAX + 1, 127));
        2: wsize = WSIZE_W'(WINDOW_MAX);
        3: wsize = WSIZE_W'($urandom_range(33, WINDOW_MAX - 1));
        default: wsize = WSIZE_W'($urandom_range(1, 12));
      endcase
      k_eff = (wsize == '0) ? 1 : ((int'(wsize) > WINDOW_MAX) ? WINDOW_MAX : int'(wsize));
      quiesce();
      if ($urandom_range(0, 7) == 0) write_reg(SPARE_ADDR, $urandom);
      write_reg(WSIZE_ADDR, PDATA_W'({$urandom, wsize}));
      case ($urandom_range(0, 3))
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 15; stall_pct = 15; end
        2: begin send_gap_pct = 45; stall_pct = 45; end
        default: begin send_gap_pct = 50; stall_pct = 0; end
      endcase
      len = (k_eff > 32) ? $urandom_range(20, 70) : $urandom_range(30, 120);
      style = $urandom_range(0, 2);
      pause_at = (phase == 0 || $urandom_range(0, 5) == 0) ? len / 2 : -1;
      for (int i = 0; i < len; i++) begin
        if (i == pause_at) quiesce();
        send_sample(rand_sample(style), EXP_MODEL, '0);
        random_sent++;
      end
      phase++;
    end

    quiesce();
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
